/* design/esc_pkg.sv */
package esc_pkg;

	typedef struct packed {
		logic [19:0] pres_adc;
		logic [19:0] temp_adc;
		logic [15:0] hum_raw;
	} in_t;

	typedef struct packed {
		logic [31:0] temp_centi_c;
		logic [31:0] press_pa;
		logic        press_valid;
		logic [16:0] hum_q10;
	} out_t;

	typedef enum logic [2:0] {
		REG_TEMP    = 3'd0,
		REG_PRESS_A = 3'd1,
		REG_PRESS_B = 3'd2,
		REG_PRESS_C = 3'd3,
		REG_HUM_A   = 3'd4,
		REG_HUM_B   = 3'd5
	} reg_index_t;

	localparam int unsigned CFG_W   = 48;
	localparam int unsigned DIV_N   = 32;
	localparam logic [31:0] HUM_MAX = 32'd419430400;

	function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

endpackage

/* design/env_sensor_compensation.sv */
// Environmental sensor compensation pipeline.
// A raw sample set (pressure, temperature, humidity) enters on the in channel
// and one compensated result leaves on the out channel: temperature in
// hundredths of a degree, pressure in pascal with a valid flag, and humidity
// in Q7.10 percent. Both channels move one beat when valid and ready are high.
// Calibration coefficients are written on the cfg channel (index, data), which
// is always ready; write them only while no beat is in flight.
// The block takes one beat every cycle while no output stall holds it. The
// depth is set by the pressure division, a restoring divider with one
// quotient bit per stage over 32 stages, plus 15 stages of multiply and
// shift ahead of it and 5 stages of pressure correction after it.
// All stages advance together: when the output holds a beat that the receiver
// does not take, the whole pipeline and in_ready stall, and nothing is lost.
// Reset clears all stage valid flags and all coefficients to zero.
module env_sensor_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  esc_pkg::in_t        in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output esc_pkg::out_t       out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_data
);
	import esc_pkg::*;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] divisor;
		logic        post;
		logic        pv;
		logic [31:0] temp;
		logic [16:0] hum;
	} div_t;

	function automatic div_t div_step(input div_t x);
		div_t        y;
		logic [32:0] r;
		logic        bit_q;
		y = x;
		r = {x.rem, x.quo[31]};
		bit_q = (r >= {1'b0, x.divisor});
		y.rem = bit_q ? 32'(r - {1'b0, x.divisor}) : r[31:0];
		y.quo = {x.quo[30:0], bit_q};
		return y;
	endfunction

	logic [CFG_W-1:0] temp_coeffs_q, press_a_q, press_b_q, press_c_q;
	logic [31:0]      hum_a_q, hum_b_q;

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;

	assign t1 = {16'b0, temp_coeffs_q[15:0]};
	assign t2 = 32'($signed(temp_coeffs_q[31:16]));
	assign t3 = 32'($signed(temp_coeffs_q[47:32]));
	assign p1 = {16'b0, press_a_q[15:0]};
	assign p2 = 32'($signed(press_a_q[31:16]));
	assign p3 = 32'($signed(press_a_q[47:32]));
	assign p4 = 32'($signed(press_b_q[15:0]));
	assign p5 = 32'($signed(press_b_q[31:16]));
	assign p6 = 32'($signed(press_b_q[47:32]));
	assign p7 = 32'($signed(press_c_q[15:0]));
	assign p8 = 32'($signed(press_c_q[31:16]));
	assign p9 = 32'($signed(press_c_q[47:32]));
	assign h1 = {24'b0, hum_a_q[7:0]};
	assign h2 = 32'($signed(hum_a_q[23:8]));
	assign h3 = {24'b0, hum_a_q[31:24]};
	assign h4 = 32'($signed(hum_b_q[11:0]));
	assign h5 = 32'($signed(hum_b_q[23:12]));
	assign h6 = 32'($signed(hum_b_q[31:24]));

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			press_c_q     <= '0;
			hum_a_q       <= '0;
			hum_b_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEMP:    temp_coeffs_q <= cfg_data;
				REG_PRESS_A: press_a_q     <= cfg_data;
				REG_PRESS_B: press_b_q     <= cfg_data;
				REG_PRESS_C: press_c_q     <= cfg_data;
				REG_HUM_A:   hum_a_q       <= cfg_data[31:0];
				REG_HUM_B:   hum_b_q       <= cfg_data[31:0];
				default:     ;
			endcase
		end
	end

	// One valid flag per stage; the last flag drives out_valid.
	localparam int unsigned NSTAGE = 15 + DIV_N + 5;
	logic [NSTAGE-1:0] vld_s;
	logic              adv;

	assign adv       = !vld_s[NSTAGE-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTAGE-2:0], in_valid};
		end
	end

	logic [31:0] a0_s1, d_s1;
	logic [19:0] praw_s1, praw_s2, praw_s3, praw_s4, praw_s5, praw_s6, praw_s7, praw_s8;
	logic [19:0] praw_s9;
	logic [15:0] hraw_s1, hraw_s2, hraw_s3, hraw_s4, hraw_s5;
	logic [31:0] ma_s2, dd_s2;
	logic [31:0] a_s3, b1_s3;
	logic [31:0] tf_s4;
	logic [31:0] t5_s5, v1_s5, h_s5;
	logic [31:0] temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11, temp_s12;
	logic [31:0] temp_s13, temp_s14, temp_s15;
	logic [31:0] sq_s6, v1p5_s6, p2v1_s6, hx_s6, h5h_s6, hh6_s6, hh3_s6;
	logic [31:0] v2a_s7, p3s_s7, v1p5_s7, p2v1_s7, ha_s7, b6_s7, b3_s7;
	logic [31:0] v2b_s8, v1b_s8, bm_s8, ha_s8;
	logic [31:0] v2c_s9, v1c_s9, bb_s9, ha_s9;
	logic [31:0] v1d_s10, nv_s10, bh_s10, ha_s10;
	logic [31:0] v1d_s11, pm_s11, hb_s11, ha_s11;
	logic [31:0] dvd_s12, dvs_s12, hm_s12;
	logic        post_s12, pv_s12;
	logic [31:0] dvd_s13, dvs_s13, hm_s13, dd2_s13;
	logic        post_s13, pv_s13;
	logic [31:0] dvd_s14, dvs_s14, hm_s14, e_s14;
	logic        post_s14, pv_s14;
	logic [31:0] dvd_s15, dvs_s15;
	logic        post_s15, pv_s15;
	logic [16:0] hum_s15;
	logic [31:0] hr;

	assign hr = hm_s14 - sra(e_s14, 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			a0_s1   <= ({12'b0, in_data.temp_adc} >> 3) - {t1[30:0], 1'b0};
			d_s1    <= ({12'b0, in_data.temp_adc} >> 4) - t1;
			praw_s1 <= in_data.pres_adc;
			hraw_s1 <= in_data.hum_raw;

			ma_s2   <= a0_s1 * t2;
			dd_s2   <= d_s1 * d_s1;
			praw_s2 <= praw_s1;
			hraw_s2 <= hraw_s1;

			a_s3    <= sra(ma_s2, 11);
			b1_s3   <= sra(dd_s2, 12) * t3;
			praw_s3 <= praw_s2;
			hraw_s3 <= hraw_s2;

			tf_s4   <= a_s3 + sra(b1_s3, 14);
			praw_s4 <= praw_s3;
			hraw_s4 <= hraw_s3;

			t5_s5   <= tf_s4 * 32'd5 + 32'd128;
			v1_s5   <= sra(tf_s4, 1) - 32'd64000;
			h_s5    <= tf_s4 - 32'd76800;
			praw_s5 <= praw_s4;
			hraw_s5 <= hraw_s4;

			temp_s6 <= sra(t5_s5, 8);
			sq_s6   <= sra(v1_s5, 2) * sra(v1_s5, 2);
			v1p5_s6 <= v1_s5 * p5;
			p2v1_s6 <= p2 * v1_s5;
			hx_s6   <= {2'b0, hraw_s5, 14'b0} - {h4[11:0], 20'b0};
			h5h_s6  <= h5 * h_s5;
			hh6_s6  <= h_s5 * h6;
			hh3_s6  <= h_s5 * h3;
			praw_s6 <= praw_s5;

			temp_s7 <= temp_s6;
			v2a_s7  <= sra(sq_s6, 11) * p6;
			p3s_s7  <= p3 * sra(sq_s6, 13);
			v1p5_s7 <= v1p5_s6;
			p2v1_s7 <= p2v1_s6;
			ha_s7   <= sra(hx_s6 - h5h_s6 + 32'd16384, 15);
			b6_s7   <= sra(hh6_s6, 10);
			b3_s7   <= sra(hh3_s6, 11) + 32'd32768;
			praw_s7 <= praw_s6;

			temp_s8 <= temp_s7;
			v2b_s8  <= v2a_s7 + {v1p5_s7[30:0], 1'b0};
			v1b_s8  <= sra(sra(p3s_s7, 3) + sra(p2v1_s7, 1), 18);
			bm_s8   <= b6_s7 * b3_s7;
			ha_s8   <= ha_s7;
			praw_s8 <= praw_s7;

			temp_s9 <= temp_s8;
			v2c_s9  <= sra(v2b_s8, 2) + {p4[15:0], 16'b0};
			v1c_s9  <= (32'd32768 + v1b_s8) * p1;
			bb_s9   <= sra(bm_s8, 10) + 32'd2097152;
			ha_s9   <= ha_s8;
			praw_s9 <= praw_s8;

			temp_s10 <= temp_s9;
			v1d_s10  <= sra(v1c_s9, 15);
			nv_s10   <= (32'd1048576 - {12'b0, praw_s9}) - sra(v2c_s9, 12);
			bh_s10   <= bb_s9 * h2;
			ha_s10   <= ha_s9;

			temp_s11 <= temp_s10;
			v1d_s11  <= v1d_s10;
			pm_s11   <= nv_s10 * 32'd3125;
			hb_s11   <= sra(bh_s10 + 32'd8192, 14);
			ha_s11   <= ha_s10;

			temp_s12 <= temp_s11;
			post_s12 <= pm_s11[31];
			dvd_s12  <= pm_s11[31] ? pm_s11 : {pm_s11[30:0], 1'b0};
			dvs_s12  <= v1d_s11;
			pv_s12   <= (v1d_s11 != 32'd0);
			hm_s12   <= ha_s11 * hb_s11;

			temp_s13 <= temp_s12;
			post_s13 <= post_s12;
			dvd_s13  <= dvd_s12;
			dvs_s13  <= dvs_s12;
			pv_s13   <= pv_s12;
			hm_s13   <= hm_s12;
			dd2_s13  <= sra(hm_s12, 15) * sra(hm_s12, 15);

			temp_s14 <= temp_s13;
			post_s14 <= post_s13;
			dvd_s14  <= dvd_s13;
			dvs_s14  <= dvs_s13;
			pv_s14   <= pv_s13;
			hm_s14   <= hm_s13;
			e_s14    <= sra(dd2_s13, 7) * h1;

			temp_s15 <= temp_s14;
			post_s15 <= post_s14;
			dvd_s15  <= dvd_s14;
			dvs_s15  <= dvs_s14;
			pv_s15   <= pv_s14;
			if (hr[31]) begin
				hum_s15 <= '0;
			end else if (hr > HUM_MAX) begin
				hum_s15 <= HUM_MAX[28:12];
			end else begin
				hum_s15 <= hr[28:12];
			end
		end
	end

	div_t div_in;
	div_t div_s [DIV_N];

	always_comb begin
		div_in.rem     = '0;
		div_in.quo     = dvd_s15;
		div_in.divisor = dvs_s15;
		div_in.post    = post_s15;
		div_in.pv      = pv_s15;
		div_in.temp    = temp_s15;
		div_in.hum     = hum_s15;
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= div_step((k == 0) ? div_in : div_s[(k == 0) ? 0 : k - 1]);
			end
		end
	end

	div_t        last;
	logic [31:0] p_s48, p_s49, qq_s49, pp8_s49, p_s50, v1e_s50, pp8_s50, p_s51, sum_s51;
	logic [31:0] p_s52;
	logic        pv_s48, pv_s49, pv_s50, pv_s51, pv_s52;
	logic [31:0] temp_s48, temp_s49, temp_s50, temp_s51, temp_s52;
	logic [16:0] hum_s48, hum_s49, hum_s50, hum_s51, hum_s52;

	assign last = div_s[DIV_N-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s48    <= last.post ? {last.quo[30:0], 1'b0} : last.quo;
			pv_s48   <= last.pv;
			temp_s48 <= last.temp;
			hum_s48  <= last.hum;

			p_s49    <= p_s48;
			qq_s49   <= (p_s48 >> 3) * (p_s48 >> 3);
			pp8_s49  <= (p_s48 >> 2) * p8;
			pv_s49   <= pv_s48;
			temp_s49 <= temp_s48;
			hum_s49  <= hum_s48;

			p_s50    <= p_s49;
			v1e_s50  <= p9 * (qq_s49 >> 13);
			pp8_s50  <= pp8_s49;
			pv_s50   <= pv_s49;
			temp_s50 <= temp_s49;
			hum_s50  <= hum_s49;

			p_s51    <= p_s50;
			sum_s51  <= sra(v1e_s50, 12) + sra(pp8_s50, 13) + p7;
			pv_s51   <= pv_s50;
			temp_s51 <= temp_s50;
			hum_s51  <= hum_s50;

			p_s52    <= pv_s51 ? p_s51 + sra(sum_s51, 4) : 32'd0;
			pv_s52   <= pv_s51;
			temp_s52 <= temp_s51;
			hum_s52  <= hum_s51;
		end
	end

	always_comb begin
		out_data.temp_centi_c = temp_s52;
		out_data.press_pa     = p_s52;
		out_data.press_valid  = pv_s52;
		out_data.hum_q10      = hum_s52;
	end

endmodule

/* tb/sv/env_sensor_compensation_tb.sv */
module env_sensor_compensation_tb;
	import esc_pkg::*;

	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int DRAIN_CYCLES = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	logic [47:0] coef [6];
	out_t        pending_results [$];
	int          errors = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          invalid_seen = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          hold_cycles = 0;

	typedef struct {
		in_t  stim;
		bit   fixed;
		out_t result;
	} row_t;

	env_sensor_compensation DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] ashr(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] sx(input logic [47:0] r, input int pos, input int w);
		logic [31:0] v;
		v = 32'((r >> pos) & ((48'd1 << w) - 1));
		if (v[w-1])
			v = v | ~((32'd1 << w) - 1);
		return v;
	endfunction

	function automatic logic [31:0] ux(input logic [47:0] r, input int pos, input int w);
		return 32'((r >> pos) & ((48'd1 << w) - 1));
	endfunction

	function automatic out_t compensate(input in_t x);
		logic [31:0] pr, tr, hr;
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [31:0] a, b, d, tf, v1, v2, sq, p, q, h;
		out_t r;
		pr = 32'(x.pres_adc);
		tr = 32'(x.temp_adc);
		hr = 32'(x.hum_raw);
		t1 = ux(coef[0], 0, 16); t2 = sx(coef[0], 16, 16); t3 = sx(coef[0], 32, 16);
		p1 = ux(coef[1], 0, 16); p2 = sx(coef[1], 16, 16); p3 = sx(coef[1], 32, 16);
		p4 = sx(coef[2], 0, 16); p5 = sx(coef[2], 16, 16); p6 = sx(coef[2], 32, 16);
		p7 = sx(coef[3], 0, 16); p8 = sx(coef[3], 16, 16); p9 = sx(coef[3], 32, 16);
		h1 = ux(coef[4], 0, 8); h2 = sx(coef[4], 8, 16); h3 = ux(coef[4], 24, 8);
		h4 = sx(coef[5], 0, 12); h5 = sx(coef[5], 12, 12); h6 = sx(coef[5], 24, 8);

		a = (tr >> 3) - (t1 << 1);
		a = ashr(a * t2, 11);
		d = (tr >> 4) - t1;
		b = ashr(d * d, 12);
		b = ashr(b * t3, 14);
		tf = a + b;
		r.temp_centi_c = ashr(tf * 32'd5 + 32'd128, 8);

		v1 = ashr(tf, 1) - 32'd64000;
		q = ashr(v1, 2);
		sq = q * q;
		v2 = ashr(sq, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = ashr(v2, 2) + (p4 << 16);
		v1 = ashr(ashr(p3 * ashr(sq, 13), 3) + ashr(p2 * v1, 1), 18);
		v1 = ashr((32'd32768 + v1) * p1, 15);
		if (v1 == 32'd0) begin
			p = '0;
			r.press_valid = 1'b0;
		end else begin
			r.press_valid = 1'b1;
			p = ((32'd1048576 - pr) - ashr(v2, 12)) * 32'd3125;
			if (p < 32'h8000_0000)
				p = (p << 1) / v1;
			else
				p = (p / v1) * 32'd2;
			q = p >> 3;
			v1 = ashr(p9 * ((q * q) >> 13), 12);
			v2 = ashr((p >> 2) * p8, 13);
			p = p + ashr(v1 + v2 + p7, 4);
		end
		r.press_pa = p;

		h = tf - 32'd76800;
		a = ashr(((hr << 14) - (h4 << 20) - (h5 * h)) + 32'd16384, 15);
		b = ashr(ashr(h * h6, 10) * (ashr(h * h3, 11) + 32'd32768), 10) + 32'd2097152;
		b = ashr(b * h2 + 32'd8192, 14);
		h = a * b;
		d = ashr(h, 15);
		h = h - ashr(ashr(d * d, 7) * h1, 4);
		if (h[31])
			h = '0;
		if (h > 32'd419430400)
			h = 32'd419430400;
		r.hum_q10 = h[28:12];
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEMP, REG_PRESS_A, REG_PRESS_B, REG_PRESS_C: coef[idx] = val;
			REG_HUM_A, REG_HUM_B: coef[idx] = {16'd0, val[31:0]};
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(input in_t x, input bit fixed, input out_t result);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(fixed ? result : compensate(x));
		beats_in++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_t random_sample();
		in_t x;
		x.pres_adc = 20'($urandom);
		x.temp_adc = 20'($urandom);
		x.hum_raw = 16'($urandom);
		if ($urandom_range(3) != 0) begin
			x.pres_adc = 20'($urandom_range(600000, 250000));
			x.temp_adc = 20'($urandom_range(600000, 400000));
			x.hum_raw = 16'($urandom_range(50000, 10000));
		end
		return x;
	endfunction

	task automatic load_coeffs(input int kind);
		logic [15:0] t1, p1;
		case (kind)
			0: begin
				write_reg(REG_TEMP, '0); write_reg(REG_PRESS_A, '0);
				write_reg(REG_PRESS_B, '0); write_reg(REG_PRESS_C, '0);
				write_reg(REG_HUM_A, '0); write_reg(REG_HUM_B, '0);
			end
			1: begin
				write_reg(REG_TEMP, '1); write_reg(REG_PRESS_A, '1);
				write_reg(REG_PRESS_B, '1); write_reg(REG_PRESS_C, '1);
				write_reg(REG_HUM_A, '1); write_reg(REG_HUM_B, '1);
			end
			2: begin
				write_reg(REG_TEMP, 48'({$urandom, $urandom}));
				write_reg(REG_PRESS_A, 48'({$urandom, $urandom}));
				write_reg(REG_PRESS_B, 48'({$urandom, $urandom}));
				write_reg(REG_PRESS_C, 48'({$urandom, $urandom}));
				write_reg(REG_HUM_A, 48'({$urandom, $urandom}));
				write_reg(REG_HUM_B, 48'({$urandom, $urandom}));
			end
			default: begin
				t1 = 16'(27504 + $urandom_range(400) - 200);
				p1 = 16'(36477 + $urandom_range(400) - 200);
				write_reg(REG_TEMP, {16'($urandom), -16'sd1000, 16'sd26435, t1});
				write_reg(REG_PRESS_A, {16'($urandom), 16'sd3024, -16'sd10685, p1});
				write_reg(REG_PRESS_B, {16'($urandom), -16'sd7, 16'sd140, 16'sd2855});
				write_reg(REG_PRESS_C, {16'($urandom), 16'sd6000, -16'sd14600, 16'sd15500});
				write_reg(REG_HUM_A, {16'($urandom), 8'd0, 16'sd362, 8'd75});
				write_reg(REG_HUM_B, {16'($urandom), 8'sd30, 12'sd0, 12'sd324});
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (out_valid && out_ready) begin
			beats_out++;
			if (!out_data.press_valid)
				invalid_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, actual %h", $time, out_data);
			end else begin
				want = pending_results.pop_front();
				if (out_data.temp_centi_c !== want.temp_centi_c) begin
					errors++;
					$display("%0t: temp_centi_c expected %h actual %h", $time,
						want.temp_centi_c, out_data.temp_centi_c);
				end
				if (out_data.press_pa !== want.press_pa) begin
					errors++;
					$display("%0t: press_pa expected %h actual %h", $time,
						want.press_pa, out_data.press_pa);
				end
				if (out_data.press_valid !== want.press_valid) begin
					errors++;
					$display("%0t: press_valid expected %b actual %b", $time,
						want.press_valid, out_data.press_valid);
				end
				if (out_data.hum_q10 !== want.hum_q10) begin
					errors++;
					$display("%0t: hum_q10 expected %h actual %h", $time,
						want.hum_q10, out_data.hum_q10);
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("[env_sensor_compensation] ERROR");
		$finish;
	end

	initial begin
		row_t rows [$];
		row_t r;
		int   idles [4][2];
		int   set_no;
		for (int i = 0; i < 6; i++)
			coef[i] = '0;
		idles = '{'{0, 0}, '{63, 0}, '{0, 63}, '{23, 23}};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With every coefficient at reset the result is zero and pressure is flagged invalid.
		r.fixed = 1'b1;
		r.result = '0;
		r.stim = '0;                                  rows.push_back(r);
		r.stim = '1;                                  rows.push_back(r);
		r.stim = '{20'hFFFFF, 20'h0, 16'hFFFF};       rows.push_back(r);
		r.stim = '{20'h0, 20'hFFFFF, 16'h0};          rows.push_back(r);
		r.stim = '{20'd519888, 20'd415148, 16'd30000}; rows.push_back(r);
		foreach (rows[i])
			send_sample(rows[i].stim, rows[i].fixed, rows[i].result);
		drain();

		load_coeffs(3);
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		rows.delete();
		r.fixed = 1'b0;
		r.stim = '{20'd519888, 20'd415148, 16'd30000}; rows.push_back(r);
		r.stim = '0;                                  rows.push_back(r);
		r.stim = '1;                                  rows.push_back(r);
		r.stim = '{20'hFFFFF, 20'h0, 16'h0};          rows.push_back(r);
		r.stim = '{20'h0, 20'hFFFFF, 16'hFFFF};       rows.push_back(r);
		r.stim = '{20'd300000, 20'd600000, 16'd65535}; rows.push_back(r);
		r.stim = '{20'd400000, 20'd200000, 16'd0};    rows.push_back(r);
		r.stim = '{20'h80000, 20'h80000, 16'h8000};   rows.push_back(r);
		foreach (rows[i])
			send_sample(rows[i].stim, rows[i].fixed, rows[i].result);
		drain();

		set_no = 0;
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 4; k++) begin
				load_coeffs(k == 0 ? (ph % 2) + 1 : (k == 1 && ph == 3 ? 0 : 3));
				send_idle = idles[ph][0];
				recv_stall = idles[ph][1];
				if (ph == 0 && k == 1)
					hold_cycles = 400;
				for (int n = 0; n < 64; n++)
					send_sample(random_sample(), 1'b0, '0);
				drain();
				set_no++;
			end
		end
		send_idle = 0;
		recv_stall = 0;
		drain();

		$display("Sent %0d samples and checked %0d results over %0d coefficient sets,",
			beats_in, beats_out, set_no + 2);
		$display("%0d of them with pressure flagged invalid, under four idling mixes.",
			invalid_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("[env_sensor_compensation] OK");
		else
			$display("[env_sensor_compensation] ERROR");
		$finish;
	end

endmodule
